// File: design/pgd_pkg.sv
// ----------------------------------------------------------------------------
// Pickup gesture detector package
// Shared widths, register indexes, reset values and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pgd_pkg;

    // Default structural parameters.
    localparam int DEF_WINDOW_DEPTH    = 22;
    localparam int DEF_MIN_SAMPLES     = 6;
    localparam int DEF_MIN_RISES       = 3;
    localparam int DEF_ANGLE_FRAC_BITS = 7;

    // Field widths.
    localparam int ANGLE_W   = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STILL_DELTA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_MAX       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_PITCH_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX       = 3'd6;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_STILL_DELTA    = 15'd90;
    localparam logic [CFG_W-1:0] RST_PITCH_LOW      = 15'd3200;
    localparam logic [CFG_W-1:0] RST_PITCH_HIGH     = 15'd10240;
    localparam logic [CFG_W-1:0] RST_RISE_MIN       = 15'd3200;
    localparam logic [CFG_W-1:0] RST_ROLL_MAX       = 15'd1664;
    localparam logic [CFG_W-1:0] RST_MEAN_PITCH_MIN = 15'd640;
    localparam logic [CFG_W-1:0] RST_STEP_MAX       = 15'd2560;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [CFG_W-1:0] still_delta;
        logic [CFG_W-1:0] pitch_low;
        logic [CFG_W-1:0] pitch_high;
        logic [CFG_W-1:0] rise_min;
        logic [CFG_W-1:0] roll_max;
        logic [CFG_W-1:0] mean_pitch_min;
        logic [CFG_W-1:0] step_max;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted reading
        logic update;    // still check, detect flag, window pushes
        logic walk;      // issue one window read
        logic finish;    // form the verdict and clear the pitch window
        logic out_load;  // move the result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eval_needed;  // valid during update
        logic walk_last;    // current read index is the last one
    } dp_status_t;

endpackage

// File: design/pgd_cfg.sv
// ----------------------------------------------------------------------------
// Pickup gesture detector configuration registers
// Seven threshold registers written through a plain write port.
// ----------------------------------------------------------------------------
module pgd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pgd_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [pgd_pkg::CFG_W-1:0]     cfg_wr_data,
    output pgd_pkg::cfg_t                 cfg
);
    import pgd_pkg::*;

    cfg_t cfg_reg;

    // Register file with reset values; writes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.still_delta    <= RST_STILL_DELTA;
            cfg_reg.pitch_low      <= RST_PITCH_LOW;
            cfg_reg.pitch_high     <= RST_PITCH_HIGH;
            cfg_reg.rise_min       <= RST_RISE_MIN;
            cfg_reg.roll_max       <= RST_ROLL_MAX;
            cfg_reg.mean_pitch_min <= RST_MEAN_PITCH_MIN;
            cfg_reg.step_max       <= RST_STEP_MAX;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_STILL_DELTA:    cfg_reg.still_delta    <= cfg_wr_data;
                REG_PITCH_LOW:      cfg_reg.pitch_low      <= cfg_wr_data;
                REG_PITCH_HIGH:     cfg_reg.pitch_high     <= cfg_wr_data;
                REG_RISE_MIN:       cfg_reg.rise_min       <= cfg_wr_data;
                REG_ROLL_MAX:       cfg_reg.roll_max       <= cfg_wr_data;
                REG_MEAN_PITCH_MIN: cfg_reg.mean_pitch_min <= cfg_wr_data;
                REG_STEP_MAX:       cfg_reg.step_max       <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/pgd_ctrl.sv
// ----------------------------------------------------------------------------
// Pickup gesture detector controller
// Sequences one request through update, window walk and verdict, and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module pgd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  pgd_pkg::dp_status_t   status,
    output pgd_pkg::ctrl_cmd_t    cmd
);
    import pgd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_WALK,
        S_DRAIN,
        S_FINISH,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.eval_needed ? S_WALK : S_DONE;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (status.walk_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the result is taken.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: design/pgd_datapath.sv
// ----------------------------------------------------------------------------
// Pickup gesture detector datapath
// Holds the previous reading, the detect flag, the two sliding windows as
// circular buffers in memories, the evaluation accumulators and the result.
// ----------------------------------------------------------------------------
module pgd_datapath #(
    parameter int WINDOW_DEPTH    = pgd_pkg::DEF_WINDOW_DEPTH,
    parameter int MIN_SAMPLES     = pgd_pkg::DEF_MIN_SAMPLES,
    parameter int MIN_RISES       = pgd_pkg::DEF_MIN_RISES,
    parameter int ANGLE_FRAC_BITS = pgd_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pgd_pkg::ctrl_cmd_t                 cmd,
    output pgd_pkg::dp_status_t                status,
    input  pgd_pkg::cfg_t                      cfg,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_pitch_angle,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_roll_angle,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_yaw_angle,
    output logic                               m_pickup_seen,
    output logic                               m_window_evaluated,
    output logic                               m_detect_active
);
    import pgd_pkg::*;

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = ANGLE_W + CW + 1;
    localparam int PW = CFG_W + CW;
    localparam logic [CW-1:0] DEPTH_C       = CW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] DEPTH_M1_C    = CW'(WINDOW_DEPTH - 1);
    localparam logic [IW-1:0] LAST_IDX_C    = IW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] MIN_SAMPLES_C = CW'(MIN_SAMPLES);
    localparam logic [CW-1:0] MIN_RISES_C   = CW'(MIN_RISES);
    localparam logic [ANGLE_W:0] ONE_DEGREE = (ANGLE_W + 1)'(1 << ANGLE_FRAC_BITS);

    // Magnitude of a 17-bit two's complement value.
    function automatic logic [ANGLE_W:0] mag17(input logic [ANGLE_W:0] v);
        return v[ANGLE_W] ? (~v + (ANGLE_W + 1)'(1)) : v;
    endfunction

    // Circular buffer address: head plus offset, wrapped at the depth.
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] head,
                                               input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(off);
        if (s >= (CW + 1)'(WINDOW_DEPTH)) begin
            s = s - (CW + 1)'(WINDOW_DEPTH);
        end
        return s[IW-1:0];
    endfunction

    // Captured request and previous reading.
    logic signed [ANGLE_W-1:0] pitch_reg, roll_reg, yaw_reg;
    logic signed [ANGLE_W-1:0] prev_pitch_reg, prev_roll_reg, prev_yaw_reg;
    logic                      detect_reg, detect_next;

    // Window bookkeeping.
    logic [IW-1:0] phead_reg, phead_next, rhead_reg, rhead_next;
    logic [CW-1:0] pcnt_reg, pcnt_next, rcnt_reg, rcnt_next;

    // Window memories and read ports.
    logic [ANGLE_W-1:0] pmem [WINDOW_DEPTH];
    logic [ANGLE_W-1:0] rmem [WINDOW_DEPTH];
    logic [ANGLE_W-1:0] prd_reg, rrd_reg;
    logic [IW-1:0]      pwr_addr, rwr_addr, prd_addr, rrd_addr;
    logic               pwr_en, rwr_en;

    // Walk state and accumulators.
    logic [IW-1:0]             idx_reg, idx_d_reg;
    logic                      rd_valid_reg;
    logic signed [SW-1:0]      psum_reg, rsum_reg;
    logic signed [ANGLE_W-1:0] prev_p_reg, start_reg, first_reg, last_reg;
    logic                      have_start_reg;
    logic [CW-1:0]             good_reg;

    // Result registers.
    logic res_pickup_reg, res_eval_reg;
    logic out_pickup_reg, out_eval_reg, out_detect_reg;

    // Still check, detect flag and window pushes from the captured reading.
    logic [ANGLE_W:0]        dpitch, droll, dyaw;
    logic                    still;
    logic signed [ANGLE_W:0] pitch_x, plow_x, phigh_x;
    logic                    p_add, r_add, p_drop, r_drop;
    logic [IW-1:0]           phead_d, rhead_d;
    logic [CW-1:0]           pcnt_d, rcnt_d;

    always_comb begin
        dpitch  = {prev_pitch_reg[ANGLE_W-1], prev_pitch_reg}
                - {pitch_reg[ANGLE_W-1], pitch_reg};
        droll   = {prev_roll_reg[ANGLE_W-1], prev_roll_reg}
                - {roll_reg[ANGLE_W-1], roll_reg};
        dyaw    = {prev_yaw_reg[ANGLE_W-1], prev_yaw_reg}
                - {yaw_reg[ANGLE_W-1], yaw_reg};
        still   = (mag17(dpitch) < {2'b00, cfg.still_delta})
               && (mag17(droll) < {2'b00, cfg.still_delta})
               && (mag17(dyaw) < {2'b00, cfg.still_delta});
        pitch_x = {pitch_reg[ANGLE_W-1], pitch_reg};
        plow_x  = {2'b00, cfg.pitch_low};
        phigh_x = {2'b00, cfg.pitch_high};

        if (still || yaw_reg[ANGLE_W-1]) begin
            detect_next = 1'b0;
        end else if (pitch_x > plow_x && pitch_x < phigh_x) begin
            detect_next = 1'b1;
        end else begin
            detect_next = detect_reg;
        end

        // Full windows drop their oldest entry on every reading.
        p_add   = pitch_x > $signed(ONE_DEGREE);
        r_add   = $signed({roll_reg[ANGLE_W-1], roll_reg}) > $signed(ONE_DEGREE);
        p_drop  = pcnt_reg >= DEPTH_C;
        r_drop  = rcnt_reg >= DEPTH_C;
        phead_d = p_drop ? ((phead_reg == LAST_IDX_C) ? '0 : phead_reg + IW'(1))
                         : phead_reg;
        rhead_d = r_drop ? ((rhead_reg == LAST_IDX_C) ? '0 : rhead_reg + IW'(1))
                         : rhead_reg;
        pcnt_d  = p_drop ? DEPTH_M1_C : pcnt_reg;
        rcnt_d  = r_drop ? DEPTH_M1_C : rcnt_reg;
        pwr_addr = wrap_add(phead_d, pcnt_d);
        rwr_addr = wrap_add(rhead_d, rcnt_d);
        pwr_en   = cmd.update && p_add;
        rwr_en   = cmd.update && r_add;
        phead_next = phead_d;
        rhead_next = rhead_d;
        pcnt_next  = pcnt_d + CW'(p_add);
        rcnt_next  = rcnt_d + CW'(r_add);
    end

    assign status.eval_needed = detect_next && (pcnt_next >= MIN_SAMPLES_C);

    // Walk addresses over both windows in parallel.
    logic [CW-1:0] walk_len;
    assign walk_len         = (pcnt_reg > rcnt_reg) ? pcnt_reg : rcnt_reg;
    assign status.walk_last = (CW'(idx_reg) + CW'(1)) == walk_len;
    assign prd_addr         = wrap_add(phead_reg, CW'(idx_reg));
    assign rrd_addr         = wrap_add(rhead_reg, CW'(idx_reg));

    // Window memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (pwr_en) begin
            pmem[pwr_addr] <= pitch_reg;
        end
        if (rwr_en) begin
            rmem[rwr_addr] <= roll_reg;
        end
        prd_reg <= pmem[prd_addr];
        rrd_reg <= rmem[rrd_addr];
    end

    // Per-entry evaluation on read data.
    logic signed [ANGLE_W-1:0] p_data, r_data;
    logic [ANGLE_W:0]          p_mag, prev_mag;
    logic signed [ANGLE_W+1:0] step;
    logic                      rising, p_in, r_in;

    always_comb begin
        p_data   = prd_reg;
        r_data   = rrd_reg;
        p_in     = rd_valid_reg && (CW'(idx_d_reg) < pcnt_reg);
        r_in     = rd_valid_reg && (CW'(idx_d_reg) < rcnt_reg);
        p_mag    = mag17({p_data[ANGLE_W-1], p_data});
        prev_mag = mag17({prev_p_reg[ANGLE_W-1], prev_p_reg});
        step     = $signed({1'b0, p_mag}) - $signed({1'b0, prev_mag});
        rising   = (prev_p_reg < p_data) && (step < $signed({3'b000, cfg.step_max}));
    end

    // Verdict terms; means are tested as sum against threshold times count.
    logic [PW-1:0]             roll_prod, pitch_prod;
    logic signed [ANGLE_W:0]   first_x, last_x, start_x, rise;
    logic                      roll_ok, first_ok, mean_ok, last_ok, rise_ok, verdict;

    always_comb begin
        roll_prod  = PW'(rcnt_reg) * PW'(cfg.roll_max);
        pitch_prod = PW'(pcnt_reg) * PW'(cfg.mean_pitch_min);
        first_x    = {first_reg[ANGLE_W-1], first_reg};
        last_x     = {last_reg[ANGLE_W-1], last_reg};
        start_x    = {start_reg[ANGLE_W-1], start_reg};
        rise       = last_x - start_x;
        roll_ok    = (rcnt_reg == '0) || !(rsum_reg > $signed(SW'(roll_prod)));
        first_ok   = !(first_x > plow_x);
        mean_ok    = !(psum_reg < $signed(SW'(pitch_prod)));
        last_ok    = (last_x < phigh_x) && (last_x > plow_x);
        rise_ok    = have_start_reg && (start_reg > 0)
                  && (rise > $signed({2'b00, cfg.rise_min}));
        verdict    = roll_ok && first_ok && mean_ok && last_ok && rise_ok
                  && (good_reg >= MIN_RISES_C);
    end

    // Control state of the datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pitch_reg <= '0;
            prev_roll_reg  <= '0;
            prev_yaw_reg   <= '0;
            detect_reg     <= 1'b0;
            phead_reg      <= '0;
            rhead_reg      <= '0;
            pcnt_reg       <= '0;
            rcnt_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            idx_reg        <= '0;
        end else begin
            rd_valid_reg <= cmd.walk;
            if (cmd.update) begin
                prev_pitch_reg <= pitch_reg;
                prev_roll_reg  <= roll_reg;
                prev_yaw_reg   <= yaw_reg;
                detect_reg     <= detect_next;
                phead_reg      <= phead_next;
                rhead_reg      <= rhead_next;
                pcnt_reg       <= pcnt_next;
                rcnt_reg       <= rcnt_next;
                idx_reg        <= '0;
            end else if (cmd.walk) begin
                idx_reg <= idx_reg + IW'(1);
            end
            // An evaluated window is emptied and stops detection.
            if (cmd.finish) begin
                pcnt_reg   <= '0;
                detect_reg <= 1'b0;
            end
        end
    end

    // Payload registers: captured request, accumulators and result.
    always_ff @(posedge aclk) begin
        idx_d_reg <= idx_reg;
        if (cmd.load) begin
            pitch_reg <= s_pitch_angle;
            roll_reg  <= s_roll_angle;
            yaw_reg   <= s_yaw_angle;
        end
        if (cmd.update) begin
            psum_reg       <= '0;
            rsum_reg       <= '0;
            prev_p_reg     <= '0;
            start_reg      <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            have_start_reg <= 1'b0;
            good_reg       <= '0;
            res_pickup_reg <= 1'b0;
            res_eval_reg   <= 1'b0;
        end else begin
            if (r_in) begin
                rsum_reg <= rsum_reg + SW'(r_data);
            end
            if (p_in) begin
                psum_reg   <= psum_reg + SW'(p_data);
                prev_p_reg <= p_data;
                if (idx_d_reg == '0) begin
                    first_reg <= p_data;
                end
                if ((CW'(idx_d_reg) + CW'(1)) == pcnt_reg) begin
                    last_reg <= p_data;
                end
                if (rising) begin
                    // The entry before the second good step starts the rise.
                    if (good_reg == CW'(1) && prev_p_reg != '0) begin
                        start_reg      <= prev_p_reg;
                        have_start_reg <= 1'b1;
                    end
                    good_reg <= good_reg + CW'(1);
                end
            end
        end
        if (cmd.finish) begin
            res_pickup_reg <= verdict;
            res_eval_reg   <= 1'b1;
        end
        if (cmd.out_load) begin
            out_pickup_reg <= res_pickup_reg;
            out_eval_reg   <= res_eval_reg;
            out_detect_reg <= detect_reg;
        end
    end

    assign m_pickup_seen      = out_pickup_reg;
    assign m_window_evaluated = out_eval_reg;
    assign m_detect_active    = out_detect_reg;

endmodule

// File: design/pickup_gesture_detector_unit.sv
// ----------------------------------------------------------------------------
// Pickup gesture detector
// Watches rotation readings for a device being lifted and reports one
// verdict per reading.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel s_*: one request is a pitch, roll and yaw reading in
//   1/2^ANGLE_FRAC_BITS degree. Output channel m_*: one result per request
//   with pickup_seen, window_evaluated and detect_active.
// - A reading that does not trigger an evaluation passes through the update
//   and done states before the next acceptance, and its result is loaded
//   into the output register from the done state.
// - A reading that triggers an evaluation walks both windows through their
//   memory read ports, one entry per cycle over the longer window (up to
//   WINDOW_DEPTH entries, 22 at the default depth), then drains and finishes.
// - The result sits in an output register; the next request is accepted
//   while it waits. When the receiver stalls with a result still held, the
//   following result waits in the datapath and no further request is taken.
// - Reset clears the previous reading, the detect flag, both window counts
//   and loads the threshold registers with their defaults. No clearing pass
//   is needed; the block is ready in the first cycle after reset.
// - Write thresholds via cfg_wr_* only while idle; the block does not check.
// ----------------------------------------------------------------------------
module pickup_gesture_detector_unit #(
    parameter int WINDOW_DEPTH    = pgd_pkg::DEF_WINDOW_DEPTH,
    parameter int MIN_SAMPLES     = pgd_pkg::DEF_MIN_SAMPLES,
    parameter int MIN_RISES       = pgd_pkg::DEF_MIN_RISES,
    parameter int ANGLE_FRAC_BITS = pgd_pkg::DEF_ANGLE_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pgd_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [pgd_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_pitch_angle,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_roll_angle,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_yaw_angle,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_pickup_seen,
    output logic                               m_window_evaluated,
    output logic                               m_detect_active
);
    import pgd_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Threshold registers.
    pgd_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    // Sequencer for one request.
    pgd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Windows, accumulators and result.
    pgd_datapath #(
        .WINDOW_DEPTH    (WINDOW_DEPTH),
        .MIN_SAMPLES     (MIN_SAMPLES),
        .MIN_RISES       (MIN_RISES),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .cfg                (cfg),
        .s_pitch_angle      (s_pitch_angle),
        .s_roll_angle       (s_roll_angle),
        .s_yaw_angle        (s_yaw_angle),
        .m_pickup_seen      (m_pickup_seen),
        .m_window_evaluated (m_window_evaluated),
        .m_detect_active    (m_detect_active)
    );

endmodule

// File: bench/pgd_verdict_check.sv
// ----------------------------------------------------------------------------
// Pickup gesture detector verdict checker
// Watches the threshold writes and both request channels, keeps its own
// copy of the detector state, predicts the verdict of every accepted
// reading and compares it field by field with the results as they leave.
// ----------------------------------------------------------------------------
module pgd_verdict_check (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pgd_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [pgd_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_pitch_angle,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_roll_angle,
    input  logic signed [pgd_pkg::ANGLE_W-1:0] s_yaw_angle,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_pickup_seen,
    input  logic                               m_window_evaluated,
    input  logic                               m_detect_active,
    output int                                 mismatch_total,
    output int                                 verdicts_pending,
    output int                                 results_total,
    output int                                 evals_total,
    output int                                 pickups_total
);
    import pgd_pkg::*;

    localparam int WIN_DEPTH   = DEF_WINDOW_DEPTH;
    localparam int MIN_SAMPLES = DEF_MIN_SAMPLES;
    localparam int MIN_RISES   = DEF_MIN_RISES;
    localparam int ONE_DEGREE  = 1 << DEF_ANGLE_FRAC_BITS;
    localparam int PITCH_WIN   = 0;
    localparam int ROLL_WIN    = 1;

    typedef struct packed {
        logic pickup;
        logic evaluated;
        logic active;
    } verdict_t;

    // Shadow of the detector: thresholds, previous reading, flag, windows.
    cfg_t     thr;
    int       last_pitch, last_roll, last_yaw;
    bit       detecting;
    int       hist [2][WIN_DEPTH];
    int       fill [2];
    verdict_t verdict_q [$];
    int       mismatches, results, evals, pickups;

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Drop the oldest entry of a full window, then add the angle if it
    // is above one degree.
    function automatic void slide_in(int w, int v);
        if (fill[w] >= WIN_DEPTH) begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
                hist[w][i] = hist[w][i + 1];
            fill[w] = WIN_DEPTH - 1;
        end
        if (v > ONE_DEGREE) begin
            hist[w][fill[w]] = v;
            fill[w]++;
        end
    endfunction

    // Judge the pitch window: roll mean, first pitch, rising steps, pitch
    // mean, last pitch bounds and the rise from start pitch to last pitch.
    function automatic bit window_verdict();
        longint total;
        int     prev_p, start_p, last_p, good, p;
        bit     have_start;
        total      = 0;
        prev_p     = 0;
        start_p    = 0;
        good       = 0;
        have_start = 1'b0;
        for (int i = 0; i < fill[ROLL_WIN]; i++)
            total += hist[ROLL_WIN][i];
        if (fill[ROLL_WIN] > 0 && total > longint'(thr.roll_max) * fill[ROLL_WIN])
            return 1'b0;
        if (fill[PITCH_WIN] == 0 || hist[PITCH_WIN][0] > int'(thr.pitch_low))
            return 1'b0;
        total = 0;
        for (int i = 0; i < fill[PITCH_WIN]; i++) begin
            p = hist[PITCH_WIN][i];
            total += p;
            if (prev_p < p && magnitude(p) - magnitude(prev_p) < int'(thr.step_max)) begin
                if (good == 1 && prev_p != 0) begin
                    start_p    = prev_p;
                    have_start = 1'b1;
                end
                good++;
            end
            prev_p = p;
        end
        if (total < longint'(thr.mean_pitch_min) * fill[PITCH_WIN])
            return 1'b0;
        last_p = hist[PITCH_WIN][fill[PITCH_WIN] - 1];
        return good >= MIN_RISES && last_p < int'(thr.pitch_high)
            && last_p > int'(thr.pitch_low) && have_start && start_p > 0
            && (last_p - start_p) > int'(thr.rise_min);
    endfunction

    // Advance the shadow state by one reading and return its verdict.
    function automatic verdict_t predict_verdict(int pitch, int roll, int yaw);
        bit       still;
        verdict_t v;
        v     = '0;
        still = magnitude(last_pitch - pitch) < int'(thr.still_delta)
             && magnitude(last_roll - roll) < int'(thr.still_delta)
             && magnitude(last_yaw - yaw) < int'(thr.still_delta);
        if (still || yaw < 0)
            detecting = 1'b0;
        else if (pitch > int'(thr.pitch_low) && pitch < int'(thr.pitch_high))
            detecting = 1'b1;
        slide_in(PITCH_WIN, pitch);
        slide_in(ROLL_WIN, roll);
        if (detecting && fill[PITCH_WIN] >= MIN_SAMPLES) begin
            v.pickup         = window_verdict();
            v.evaluated      = 1'b1;
            fill[PITCH_WIN]  = 0;
            detecting        = 1'b0;
        end
        last_pitch = pitch;
        last_roll  = roll;
        last_yaw   = yaw;
        v.active   = detecting;
        return v;
    endfunction

    task automatic check_field(string name, logic want, logic got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0b, got %0b", $time, name, want, got);
        end
    endtask

    // Track writes and requests, then compare each result with the oldest
    // verdict still owed.
    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            thr        = '{RST_STILL_DELTA, RST_PITCH_LOW, RST_PITCH_HIGH, RST_RISE_MIN,
                           RST_ROLL_MAX, RST_MEAN_PITCH_MIN, RST_STEP_MAX};
            last_pitch = 0;
            last_roll  = 0;
            last_yaw   = 0;
            detecting  = 1'b0;
            fill[PITCH_WIN] = 0;
            fill[ROLL_WIN]  = 0;
            verdict_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_STILL_DELTA:    thr.still_delta    = cfg_wr_data;
                    REG_PITCH_LOW:      thr.pitch_low      = cfg_wr_data;
                    REG_PITCH_HIGH:     thr.pitch_high     = cfg_wr_data;
                    REG_RISE_MIN:       thr.rise_min       = cfg_wr_data;
                    REG_ROLL_MAX:       thr.roll_max       = cfg_wr_data;
                    REG_MEAN_PITCH_MIN: thr.mean_pitch_min = cfg_wr_data;
                    REG_STEP_MAX:       thr.step_max       = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                verdict_q.push_back(predict_verdict(int'(s_pitch_angle),
                                                    int'(s_roll_angle),
                                                    int'(s_yaw_angle)));
            if (m_valid && m_ready) begin
                results++;
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %0b%0b%0b",
                             $time, m_pickup_seen, m_window_evaluated, m_detect_active);
                end else begin
                    want = verdict_q.pop_front();
                    evals   += want.evaluated;
                    pickups += want.pickup;
                    check_field("pickup_seen", want.pickup, m_pickup_seen);
                    check_field("window_evaluated", want.evaluated, m_window_evaluated);
                    check_field("detect_active", want.active, m_detect_active);
                end
            end
        end
        mismatch_total   <= mismatches;
        verdicts_pending <= verdict_q.size();
        results_total    <= results;
        evals_total      <= evals;
        pickups_total    <= pickups;
    end

    initial begin
        mismatches = 0;
        results    = 0;
        evals      = 0;
        pickups    = 0;
    end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Pickup gesture detector testbench
// Drives rotation readings through the detector under several threshold
// settings: a directed opening, then lifting gestures with random content
// mixed with noise, still and broken readings. Both channels idle at
// random. A separate checker predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import pgd_pkg::*;

    localparam int ANGLE_MAX    = 23040;
    localparam int ONE_DEGREE   = 1 << DEF_ANGLE_FRAC_BITS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_wr_index;
    logic [CFG_W-1:0]          cfg_wr_data;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [ANGLE_W-1:0] s_pitch_angle;
    logic signed [ANGLE_W-1:0] s_roll_angle;
    logic signed [ANGLE_W-1:0] s_yaw_angle;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_pickup_seen;
    logic                      m_window_evaluated;
    logic                      m_detect_active;

    int   mismatch_total, verdicts_pending, results_total, evals_total, pickups_total;
    int   cycle_count = 0;
    int   ready_hold = 0;
    int   sent_count = 0;
    int   settings_used = 1;
    int   sent_pitch, sent_roll, sent_yaw;
    bit   idle_on = 1'b1;
    cfg_t cur;

    pickup_gesture_detector_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pitch_angle      (s_pitch_angle),
        .s_roll_angle       (s_roll_angle),
        .s_yaw_angle        (s_yaw_angle),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_pickup_seen      (m_pickup_seen),
        .m_window_evaluated (m_window_evaluated),
        .m_detect_active    (m_detect_active)
    );

    pgd_verdict_check u_verdict_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pitch_angle      (s_pitch_angle),
        .s_roll_angle       (s_roll_angle),
        .s_yaw_angle        (s_yaw_angle),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_pickup_seen      (m_pickup_seen),
        .m_window_evaluated (m_window_evaluated),
        .m_detect_active    (m_detect_active),
        .mismatch_total     (mismatch_total),
        .verdicts_pending   (verdicts_pending),
        .results_total      (results_total),
        .evals_total        (evals_total),
        .pickups_total      (pickups_total)
    );

    always #5 aclk = ~aclk;

    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clip_angle(int v);
        return (v > ANGLE_MAX) ? ANGLE_MAX : (v < -ANGLE_MAX) ? -ANGLE_MAX : v;
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = rnd(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return rnd(1, 4);
        return rnd(10, 40);
    endfunction

    // Receiver: ready high or low for stretches of random length.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= !idle_on || rnd(0, 2) != 0;
            ready_hold <= pick_gap();
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d verdicts owed",
                     cycle_count, verdicts_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One request: an optional gap with valid low, then hold it until taken.
    task automatic send_reading(int pitch, int roll, int yaw);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pitch_angle <= ANGLE_W'(pitch);
        s_roll_angle  <= ANGLE_W'(roll);
        s_yaw_angle   <= ANGLE_W'(yaw);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_pitch = pitch;
        sent_roll  = roll;
        sent_yaw   = yaw;
        sent_count++;
    endtask

    // Stop sending and wait until every verdict owed has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (verdicts_pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
    endtask

    task automatic apply_setting(cfg_t s);
        write_reg(REG_STILL_DELTA, s.still_delta);
        write_reg(REG_PITCH_LOW, s.pitch_low);
        write_reg(REG_PITCH_HIGH, s.pitch_high);
        write_reg(REG_RISE_MIN, s.rise_min);
        write_reg(REG_ROLL_MAX, s.roll_max);
        write_reg(REG_MEAN_PITCH_MIN, s.mean_pitch_min);
        write_reg(REG_STEP_MAX, s.step_max);
        cfg_wr_en <= 1'b0;
        cur = s;
        settings_used++;
    endtask

    // Rolls mostly stay under one degree so the roll mean rarely rejects.
    function automatic int gesture_roll();
        return (rnd(0, 3) != 0) ? rnd(-ONE_DEGREE, ONE_DEGREE) : rnd(ONE_DEGREE + 1, 2500);
    endfunction

    // A negative yaw now and then breaks the gesture.
    function automatic int gesture_yaw();
        return (rnd(0, 19) == 0) ? -rnd(1, ANGLE_MAX) : rnd(0, ANGLE_MAX);
    endfunction

    // A lift: pitch climbs from near flat up to the lower bound, then
    // lands between the bounds, which arms the detector.
    task automatic send_gesture();
        int n_rise, n_top, lo, hi, base, p;
        lo     = int'(cur.pitch_low);
        hi     = int'(cur.pitch_high);
        n_rise = rnd(3, 8);
        n_top  = rnd(1, 3);
        base   = rnd(ONE_DEGREE + 1, 700);
        for (int k = 0; k < n_rise; k++) begin
            p = (lo > base) ? base + (lo - base) * k / n_rise : base + 300 * k;
            send_reading(clip_angle(p + rnd(-40, 40)), gesture_roll(), gesture_yaw());
        end
        for (int k = 1; k <= n_top; k++) begin
            p = (hi > lo + 1) ? lo + (hi - lo) * k / (n_top + 1) : lo + rnd(1, 500);
            send_reading(clip_angle(p), gesture_roll(), gesture_yaw());
        end
    endtask

    // Noise: wild readings, still readings, negative yaw, flat pitch.
    task automatic send_noise();
        int kind;
        kind = rnd(0, 9);
        if (kind < 5)
            send_reading(rnd(-ANGLE_MAX, ANGLE_MAX), rnd(-ANGLE_MAX, ANGLE_MAX),
                         rnd(-ANGLE_MAX, ANGLE_MAX));
        else if (kind < 7)
            send_reading(clip_angle(sent_pitch + rnd(-2, 2)), clip_angle(sent_roll + rnd(-2, 2)),
                         clip_angle(sent_yaw + rnd(-2, 2)));
        else if (kind < 9)
            send_reading(rnd(-ANGLE_MAX, ANGLE_MAX), rnd(-ANGLE_MAX, ANGLE_MAX),
                         -rnd(1, ANGLE_MAX));
        else
            send_reading(rnd(-ONE_DEGREE, ONE_DEGREE), rnd(-ANGLE_MAX, ANGLE_MAX),
                         rnd(-ANGLE_MAX, ANGLE_MAX));
    endtask

    task automatic random_until(int target);
        while (sent_count < target) begin
            if (rnd(0, 9) < 7)
                send_gesture();
            else
                send_noise();
        end
    endtask

    initial begin
        cfg_t s;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = '0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_pitch_angle = '0;
        s_roll_angle  = '0;
        s_yaw_angle   = '0;
        sent_pitch    = 0;
        sent_roll     = 0;
        sent_yaw      = 0;
        cur = '{RST_STILL_DELTA, RST_PITCH_LOW, RST_PITCH_HIGH, RST_RISE_MIN,
                RST_ROLL_MAX, RST_MEAN_PITCH_MIN, RST_STEP_MAX};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Clean lift with an empty roll window: a pickup.
        send_reading(500, 0, 100);
        send_reading(1200, 0, 300);
        send_reading(2000, 0, 500);
        send_reading(2800, 0, 700);
        send_reading(4500, 0, 900);
        send_reading(6000, 0, 1100);
        // Falling pitch: evaluated, but no start pitch and no pickup.
        send_reading(3000, 60, 1200);
        send_reading(2500, -60, 1400);
        send_reading(2000, 0, 1600);
        send_reading(1500, 0, 1800);
        send_reading(1000, 0, 2000);
        send_reading(5000, 0, 2200);
        // Field extremes, the one degree edge, negative yaw and a still pair.
        send_reading(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
        send_reading(-ANGLE_MAX, -ANGLE_MAX, -ANGLE_MAX);
        send_reading(-1, -1, -1);
        send_reading(0, 0, 0);
        send_reading(ONE_DEGREE, ONE_DEGREE, ONE_DEGREE);
        send_reading(ONE_DEGREE + 1, ONE_DEGREE + 1, ONE_DEGREE + 1);
        send_reading(ONE_DEGREE + 11, ONE_DEGREE + 11, ONE_DEGREE + 21);
        send_reading(ANGLE_MAX, -ANGLE_MAX, 0);
        send_reading(-ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
        send_reading(16384, 16384, 16384);

        random_until(420);

        // All thresholds at zero: detection never arms, windows fill up.
        drain_results();
        apply_setting('{default: '0});
        random_until(580);

        // All thresholds set to ANGLE_MAX, the largest angle the bench drives.
        drain_results();
        s = '{default: CFG_W'(ANGLE_MAX)};
        apply_setting(s);
        random_until(780);

        // Defaults written back; the first stretch runs without idling.
        drain_results();
        s = '{RST_STILL_DELTA, RST_PITCH_LOW, RST_PITCH_HIGH, RST_RISE_MIN,
              RST_ROLL_MAX, RST_MEAN_PITCH_MIN, RST_STEP_MAX};
        apply_setting(s);
        idle_on = 1'b0;
        random_until(950);
        idle_on = 1'b1;
        random_until(1200);

        // A random but workable setting.
        drain_results();
        s.still_delta    = CFG_W'(rnd(0, 300));
        s.pitch_low      = CFG_W'(rnd(500, 6000));
        s.pitch_high     = CFG_W'(rnd(int'(s.pitch_low) + 1000, ANGLE_MAX));
        s.rise_min       = CFG_W'(rnd(0, 8000));
        s.roll_max       = CFG_W'(rnd(0, ANGLE_MAX));
        s.mean_pitch_min = CFG_W'(rnd(0, 5000));
        s.step_max       = CFG_W'(rnd(0, ANGLE_MAX));
        apply_setting(s);
        random_until(1672);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d readings under %0d threshold settings,", results_total,
                 settings_used);
        $display("with %0d window evaluations and %0d pickups.", evals_total, pickups_total);
        if (mismatch_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
design/pgd_pkg.sv
design/pgd_cfg.sv
design/pgd_ctrl.sv
design/pgd_datapath.sv
design/pickup_gesture_detector_unit.sv
bench/pgd_verdict_check.sv
bench/tb_top.sv
